// File: design/b62id_pkg.sv
// ----------------------------------------------------------------------------
// b62id_pkg
// Shared types, field widths, command and register codes, and the base-62
// character map for the base-62 ID generator.
// ----------------------------------------------------------------------------
package b62id_pkg;

    localparam int SEQ_BITS    = 20;
    localparam int PREFIX_MAX  = 15;

    localparam int COUNT_W     = 64;
    localparam int TOTAL_W     = 32;
    localparam int SECS_W      = 44;
    localparam int IN_DATA_W   = 48;
    localparam int DIGIT_W     = 6;
    localparam int CHAR_W      = 8;
    localparam int OUT_DATA_W  = CHAR_W + TOTAL_W;
    localparam int PLEN_W      = 4;
    localparam int PHIGH_W     = 56;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;

    // Divide-by-62 unit: one 16-bit chunk of the dividend per cycle
    localparam int CHUNK_W     = 16;
    localparam int CHUNKS      = COUNT_W / CHUNK_W;
    localparam int CHUNK_IDX_W = $clog2(CHUNKS);
    localparam int DIVIN_W     = DIGIT_W + CHUNK_W;
    localparam int PROD_W      = 2 * DIVIN_W;
    localparam int RECIP_SHIFT = 27;
    // floor(2^27 / 62); estimate is exact or one low for 22-bit inputs
    localparam logic [DIVIN_W-1:0] RECIP = DIVIN_W'(2164802);
    localparam logic [DIGIT_W:0]   RADIX = 7'd62;

    localparam int QUEUE_DEPTH = 2;

    localparam logic CMD_SEED     = 1'b0;
    localparam logic CMD_GENERATE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_LEN  = 2'd2;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [TOTAL_W-1:0] total;
    } gen_job_t;

    typedef struct packed {
        logic [COUNT_W-1:0] prefix_low;
        logic [PHIGH_W-1:0] prefix_high;
        logic [PLEN_W-1:0]  prefix_len;
    } prefix_cfg_t;

    // 0-9, A-Z, a-z; codes 62 and 63 wrap around modulo 62
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        logic [CHAR_W-1:0] c;
        dx = {2'b00, d};
        case (d) inside
            [6'd0:6'd9]:   c = 8'h30 + dx;
            [6'd10:6'd35]: c = 8'h41 + (dx - 8'd10);
            [6'd36:6'd61]: c = 8'h61 + (dx - 8'd36);
            default:       c = 8'h30 + (dx - 8'd62);
        endcase
        return c;
    endfunction

endpackage

// File: design/base62_unique_id_generator_core.sv
// A generate transaction is converted to its base-62 digits (at most 11 for a 64-bit
//   counter) before its first character is shown.
// Each identifier emits at most MAX_ID_LEN characters, and the next job can be converted
//   while they are emitted; the divide-by-62 unit takes one 16-bit chunk per cycle.
// Seed transactions give no output.
// Reset clears counter, generated total, prefix registers and queues; no clearing pass.
// ----------------------------------------------------------------------------
// base62_unique_id_generator_core
// Top level: command front end, job queue, base-62 converter, character
// emitter and the prefix configuration registers.
// ----------------------------------------------------------------------------
module base62_unique_id_generator_core #(
    parameter int MAX_ID_LEN  = 32,
    parameter int DIGIT_SLOTS = 11
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [b62id_pkg::IN_DATA_W-1:0]      s_tdata,   // [43:0] seed_seconds
    input  logic                                 s_tuser,   // [0] cmd
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [b62id_pkg::OUT_DATA_W-1:0]     m_tdata,   // [7:0] char_code, [39:8] ids_generated
    output logic                                 m_tlast,   // is_last
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [b62id_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [b62id_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import b62id_pkg::*;

    localparam int NDIG_W = $clog2(DIGIT_SLOTS + 1);

    logic [COUNT_W-1:0]             prefix_low_reg;
    logic [PHIGH_W-1:0]             prefix_high_reg;
    logic [PLEN_W-1:0]              prefix_len_reg;
    prefix_cfg_t                    cfg;

    logic                           q_push, q_full, q_pop, q_empty;
    gen_job_t                       q_push_data, q_pop_data;

    logic                           cv_valid, cv_ready;
    logic [DIGIT_SLOTS*DIGIT_W-1:0] cv_digits;
    logic [NDIG_W-1:0]              cv_ndig;
    logic [TOTAL_W-1:0]             cv_total;

    assign cfg_ready = 1'b1;
    assign cfg       = '{prefix_low: prefix_low_reg, prefix_high: prefix_high_reg,
                         prefix_len: prefix_len_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_low_reg  <= '0;
            prefix_high_reg <= '0;
            prefix_len_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PREFIX_LOW:  prefix_low_reg  <= cfg_data;
                CFG_PREFIX_HIGH: prefix_high_reg <= cfg_data[PHIGH_W-1:0];
                CFG_PREFIX_LEN:  prefix_len_reg  <= cfg_data[PLEN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    b62id_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full)
    );

    b62id_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    b62id_conv #(
        .DIGIT_SLOTS (DIGIT_SLOTS),
        .NDIG_W      (NDIG_W)
    ) u_conv (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_empty  (q_empty),
        .job_pop    (q_pop),
        .job_data   (q_pop_data),
        .out_valid  (cv_valid),
        .out_ready  (cv_ready),
        .out_digits (cv_digits),
        .out_ndig   (cv_ndig),
        .out_total  (cv_total)
    );

    b62id_emit #(
        .MAX_ID_LEN  (MAX_ID_LEN),
        .DIGIT_SLOTS (DIGIT_SLOTS),
        .NDIG_W      (NDIG_W)
    ) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (cv_valid),
        .in_ready  (cv_ready),
        .in_digits (cv_digits),
        .in_ndig   (cv_ndig),
        .in_total  (cv_total),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// File: design/b62id_fifo.sv
// ----------------------------------------------------------------------------
// b62id_fifo
// Small job queue between the command front end and the conversion back end.
// ----------------------------------------------------------------------------
module b62id_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  b62id_pkg::gen_job_t push_data,
    output logic                full,
    input  logic                pop,
    output b62id_pkg::gen_job_t pop_data,
    output logic                empty
);
    import b62id_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    gen_job_t         mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("job queue overflow");

endmodule

// File: design/b62id_front.sv
// ----------------------------------------------------------------------------
// b62id_front
// Accepts command transactions, keeps the ID counter and generated total,
// and queues one job per generate command.
// ----------------------------------------------------------------------------
module b62id_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [b62id_pkg::IN_DATA_W-1:0]     s_tdata,   // [43:0] seed_seconds
    input  logic                                s_tuser,   // [0] cmd
    output logic                                push,
    output b62id_pkg::gen_job_t                 push_data,
    input  logic                                full
);
    import b62id_pkg::*;

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [COUNT_W-1:0] count_inc;
    logic [TOTAL_W-1:0] total_inc;
    logic               accept;

    assign s_tready  = !full;
    assign accept    = s_tvalid && s_tready;
    assign count_inc = count_reg + 64'd1;
    assign total_inc = total_reg + 32'd1;
    assign push_data = '{count: count_inc, total: total_inc};

    always_comb
    begin
        count_next = count_reg;
        total_next = total_reg;
        push       = 1'b0;
        if (accept)
        begin
            if (s_tuser == CMD_GENERATE)
            begin
                count_next = count_inc;
                total_next = total_inc;
                push       = 1'b1;
            end
            else
            begin
                count_next = COUNT_W'(s_tdata[SECS_W-1:0]) << SEQ_BITS;
                total_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            total_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            total_reg <= total_next;
        end
    end

endmodule

// File: design/b62id_conv.sv
// ----------------------------------------------------------------------------
// b62id_conv
// Base-62 conversion: repeated divide-by-62 of the counter, one 16-bit chunk
// per cycle, collecting remainders least significant digit first.
// ----------------------------------------------------------------------------
module b62id_conv #(
    parameter int DIGIT_SLOTS = 11,
    parameter int NDIG_W      = $clog2(DIGIT_SLOTS + 1)
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      job_empty,
    output logic                                      job_pop,
    input  b62id_pkg::gen_job_t                       job_data,
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output logic [DIGIT_SLOTS*b62id_pkg::DIGIT_W-1:0] out_digits,
    output logic [NDIG_W-1:0]                         out_ndig,
    output logic [b62id_pkg::TOTAL_W-1:0]             out_total
);
    import b62id_pkg::*;

    localparam int DIDX_W = $clog2(DIGIT_SLOTS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [CHUNK_IDX_W-1:0] chunk_reg, chunk_next;
    logic [NDIG_W-1:0]      ndig_reg, ndig_next;
    logic [DIGIT_W-1:0]     r_reg, r_next;
    logic [COUNT_W-1:0]     n_reg, n_next;
    logic [TOTAL_W-1:0]     total_reg, total_next;
    logic [DIGIT_W-1:0]     dbuf_reg [DIGIT_SLOTS];
    logic                   dig_we;

    logic [DIVIN_W-1:0]     x;
    logic [PROD_W-1:0]      prod;
    logic [CHUNK_W-1:0]     q_est, q_fix;
    logic [DIVIN_W:0]       mul62, r_full;
    logic [DIGIT_W:0]       r7;
    logic [DIGIT_W-1:0]     r_fix;
    logic [COUNT_W-1:0]     n_step;

    // One long-division step: {remainder, chunk} / 62 via reciprocal + fixup
    always_comb
    begin
        x      = {r_reg, n_reg[chunk_reg*CHUNK_W +: CHUNK_W]};
        prod   = PROD_W'(x) * PROD_W'(RECIP);
        q_est  = prod[RECIP_SHIFT +: CHUNK_W];
        mul62  = (DIVIN_W+1)'({q_est, 6'b0}) - (DIVIN_W+1)'({q_est, 1'b0});
        r_full = (DIVIN_W+1)'(x) - mul62;
        r7     = r_full[DIGIT_W:0];
        if (r7 >= RADIX)
        begin
            q_fix = q_est + 16'd1;
            r_fix = DIGIT_W'(r7 - RADIX);
        end
        else
        begin
            q_fix = q_est;
            r_fix = r7[DIGIT_W-1:0];
        end
        n_step = n_reg;
        n_step[chunk_reg*CHUNK_W +: CHUNK_W] = q_fix;
    end

    always_comb
    begin
        state_next = state_reg;
        chunk_next = chunk_reg;
        ndig_next  = ndig_reg;
        r_next     = r_reg;
        n_next     = n_reg;
        total_next = total_reg;
        job_pop    = 1'b0;
        dig_we     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!job_empty)
                begin
                    job_pop    = 1'b1;
                    n_next     = job_data.count;
                    total_next = job_data.total;
                    r_next     = '0;
                    chunk_next = CHUNK_IDX_W'(CHUNKS - 1);
                    ndig_next  = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                n_next = n_step;
                r_next = r_fix;
                if (chunk_reg == '0)
                begin
                    // Quotient complete: remainder is the next digit
                    dig_we     = 1'b1;
                    r_next     = '0;
                    chunk_next = CHUNK_IDX_W'(CHUNKS - 1);
                    ndig_next  = ndig_reg + 1'b1;
                    if ((n_step == '0) || (ndig_reg == NDIG_W'(DIGIT_SLOTS - 1)))
                    begin
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    chunk_next = chunk_reg - 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            chunk_reg <= '0;
            ndig_reg  <= '0;
            r_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            chunk_reg <= chunk_next;
            ndig_reg  <= ndig_next;
            r_reg     <= r_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        total_reg <= total_next;
        if (dig_we)
        begin
            dbuf_reg[ndig_reg[DIDX_W-1:0]] <= r_fix;
        end
    end

    always_comb
    begin
        for (int i = 0; i < DIGIT_SLOTS; i++)
        begin
            out_digits[i*DIGIT_W +: DIGIT_W] = dbuf_reg[i];
        end
    end

    assign out_valid = (state_reg == ST_DONE);
    assign out_ndig  = ndig_reg;
    assign out_total = total_reg;

    rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (r_reg < RADIX[DIGIT_W-1:0]))
        else $error("partial remainder out of range");

    ndig_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> ((ndig_reg != '0) && (ndig_reg <= NDIG_W'(DIGIT_SLOTS))))
        else $error("digit count out of range");

endmodule

// File: design/b62id_emit.sv
// ----------------------------------------------------------------------------
// b62id_emit
// Character emitter: prefix bytes, then digits most significant first,
// truncated to the maximum length, through a registered output stage.
// ----------------------------------------------------------------------------
module b62id_emit #(
    parameter int MAX_ID_LEN  = 32,
    parameter int DIGIT_SLOTS = 11,
    parameter int NDIG_W      = $clog2(DIGIT_SLOTS + 1)
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  b62id_pkg::prefix_cfg_t                    cfg,
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  logic [DIGIT_SLOTS*b62id_pkg::DIGIT_W-1:0] in_digits,
    input  logic [NDIG_W-1:0]                         in_ndig,
    input  logic [b62id_pkg::TOTAL_W-1:0]             in_total,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    output logic [b62id_pkg::OUT_DATA_W-1:0]          m_tdata,
    output logic                                      m_tlast
);
    import b62id_pkg::*;

    localparam int DIDX_W = $clog2(DIGIT_SLOTS);
    localparam int SUM_W  = $clog2(MAX_ID_LEN + PREFIX_MAX + DIGIT_SLOTS + 1);

    logic                 active_reg, active_next;
    logic [SUM_W-1:0]     pos_reg, pos_next;
    logic [SUM_W-1:0]     last_pos_reg, last_pos_next;
    logic [PLEN_W-1:0]    plen_reg, plen_next;
    logic [DIDX_W-1:0]    didx_reg, didx_next;
    logic [DIGIT_W-1:0]   dig_reg [DIGIT_SLOTS];
    logic [TOTAL_W-1:0]   total_reg;

    logic                 mvalid_reg, mvalid_next;
    logic [CHAR_W-1:0]    mchar_reg, mchar_next;
    logic                 mlast_reg, mlast_next;
    logic [TOTAL_W-1:0]   mtotal_reg;

    logic                 load;
    logic                 adv;
    logic [PLEN_W-1:0]    plen_eff;
    logic [SUM_W-1:0]     id_len_raw;
    logic [SUM_W-1:0]     id_len;
    logic [127:0]         prefix_vec;
    logic                 in_prefix;

    assign in_ready   = !active_reg;
    assign load       = in_valid && !active_reg;
    assign adv        = active_reg && (!mvalid_reg || m_tready);
    assign plen_eff   = (cfg.prefix_len > PLEN_W'(PREFIX_MAX)) ? PLEN_W'(PREFIX_MAX)
                                                               : cfg.prefix_len;
    assign id_len_raw = SUM_W'(plen_eff) + SUM_W'(in_ndig);
    assign id_len     = (id_len_raw > SUM_W'(MAX_ID_LEN)) ? SUM_W'(MAX_ID_LEN) : id_len_raw;
    assign prefix_vec = {8'h00, cfg.prefix_high, cfg.prefix_low};
    assign in_prefix  = (pos_reg < SUM_W'(plen_reg));

    always_comb
    begin
        active_next   = active_reg;
        pos_next      = pos_reg;
        last_pos_next = last_pos_reg;
        plen_next     = plen_reg;
        didx_next     = didx_reg;
        mvalid_next   = mvalid_reg;
        mchar_next    = mchar_reg;
        mlast_next    = mlast_reg;
        if (load)
        begin
            active_next   = 1'b1;
            pos_next      = '0;
            last_pos_next = id_len - 1'b1;
            plen_next     = plen_eff;
            didx_next     = in_ndig[DIDX_W-1:0] - 1'b1;
        end
        if (adv)
        begin
            mvalid_next = 1'b1;
            mlast_next  = (pos_reg == last_pos_reg);
            if (in_prefix)
            begin
                mchar_next = prefix_vec[pos_reg[3:0]*CHAR_W +: CHAR_W];
            end
            else
            begin
                mchar_next = digit_char(dig_reg[didx_reg]);
                didx_next  = didx_reg - 1'b1;
            end
            pos_next = pos_reg + 1'b1;
            if (pos_reg == last_pos_reg)
            begin
                active_next = 1'b0;
            end
        end
        else if (m_tready)
        begin
            mvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            pos_reg      <= '0;
            last_pos_reg <= '0;
            plen_reg     <= '0;
            didx_reg     <= '0;
            mvalid_reg   <= 1'b0;
            mlast_reg    <= 1'b0;
        end
        else
        begin
            active_reg   <= active_next;
            pos_reg      <= pos_next;
            last_pos_reg <= last_pos_next;
            plen_reg     <= plen_next;
            didx_reg     <= didx_next;
            mvalid_reg   <= mvalid_next;
            mlast_reg    <= mlast_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mchar_reg <= mchar_next;
        if (adv)
        begin
            mtotal_reg <= total_reg;
        end
        if (load)
        begin
            total_reg <= in_total;
            for (int i = 0; i < DIGIT_SLOTS; i++)
            begin
                dig_reg[i] <= in_digits[i*DIGIT_W +: DIGIT_W];
            end
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {mtotal_reg, mchar_reg};
    assign m_tlast  = mlast_reg;

    pos_within_len: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> ((pos_reg <= last_pos_reg) && (last_pos_reg < SUM_W'(MAX_ID_LEN))))
        else $error("emit position beyond identifier length");

    last_ends_id: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && (pos_reg == last_pos_reg)) |=> !active_reg)
        else $error("emitter still busy after final character");

endmodule
